// File: rtl/swerm_pkg.sv
package swerm_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STAMP_W = 63;
    localparam int RATE_W  = 11;
    localparam int REM_W   = 4;

    localparam logic [STAMP_W-1:0] KEEP_US      = STAMP_W'(64'd300000000);
    localparam logic [STAMP_W-1:0] MINUTE_US    = STAMP_W'(64'd60000000);
    localparam logic [STAMP_W-1:0] THREE_MIN_US = STAMP_W'(64'd180000000);

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic load;
        logic start_scan;
        logic drop_rd;
        logic drop_adv;
        logic write_stamp;
        logic scan_rd;
    } swerm_cmd_t;

    typedef struct packed {
        logic kept_zero;
        logic drop_ok;
        logic scan_more;
        logic pipe_busy;
    } swerm_status_t;

endpackage

// File: rtl/swerm_dp.sv
module swerm_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  swerm_pkg::swerm_cmd_t          cmd,
    input  logic [swerm_pkg::STAMP_W-1:0]  now_us,
    output swerm_pkg::swerm_status_t       status,
    output logic [swerm_pkg::RATE_W-1:0]   rate_one_minute,
    output logic [swerm_pkg::RATE_W-1:0]   rate_three_minutes,
    output logic [swerm_pkg::RATE_W-1:0]   rate_five_minutes
);

    function automatic logic [swerm_pkg::ADDR_W-1:0] ring_pos(
        input logic [swerm_pkg::ADDR_W-1:0] base,
        input logic [swerm_pkg::CNT_W-1:0]  off
    );
        logic [swerm_pkg::CNT_W:0] sum;
        sum = (swerm_pkg::CNT_W+1)'(base) + (swerm_pkg::CNT_W+1)'(off);
        if (sum >= (swerm_pkg::CNT_W+1)'(swerm_pkg::DEPTH))
        begin
            sum = sum - (swerm_pkg::CNT_W+1)'(swerm_pkg::DEPTH);
        end
        return sum[swerm_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [swerm_pkg::RATE_W-1:0] sat_rate(
        input logic [swerm_pkg::CNT_W-1:0] q
    );
        logic [swerm_pkg::CNT_W+swerm_pkg::RATE_W-1:0] wide;
        wide = {{swerm_pkg::RATE_W{1'b0}}, q};
        if (wide > (swerm_pkg::CNT_W+swerm_pkg::RATE_W)'(swerm_pkg::RATE_MAX))
        begin
            return swerm_pkg::RATE_MAX;
        end
        return wide[swerm_pkg::RATE_W-1:0];
    endfunction

    logic [swerm_pkg::STAMP_W-1:0] stamp_mem [swerm_pkg::DEPTH];

    logic [swerm_pkg::ADDR_W-1:0]  oldest_reg;
    logic [swerm_pkg::CNT_W-1:0]   kept_reg;
    logic [swerm_pkg::CNT_W-1:0]   scan_idx_reg;
    logic                          rd_vld_reg;
    logic                          hit_vld_reg;

    logic [swerm_pkg::STAMP_W-1:0] now_reg;
    logic [swerm_pkg::STAMP_W-1:0] limit_reg;
    logic                          early_keep_reg;
    logic [swerm_pkg::STAMP_W-1:0] thr1_reg;
    logic [swerm_pkg::STAMP_W-1:0] thr3_reg;
    logic [swerm_pkg::STAMP_W-1:0] thr5_reg;
    logic                          early1_reg;
    logic                          early3_reg;
    logic                          early5_reg;

    logic [swerm_pkg::STAMP_W-1:0] rd_data_reg;
    logic                          hit1_reg;
    logic                          hit3_reg;
    logic                          hit5_reg;

    logic [swerm_pkg::CNT_W-1:0]   q1_reg;
    logic [swerm_pkg::CNT_W-1:0]   q3_reg;
    logic [swerm_pkg::CNT_W-1:0]   q5_reg;
    logic [swerm_pkg::REM_W-1:0]   r3_reg;
    logic [swerm_pkg::REM_W-1:0]   r5_reg;

    logic                          kept_full;
    logic [swerm_pkg::ADDR_W-1:0]  rd_addr;
    logic [swerm_pkg::ADDR_W-1:0]  wr_addr;
    logic [swerm_pkg::REM_W-1:0]   r3_sum;
    logic [swerm_pkg::REM_W-1:0]   r5_sum;

    assign kept_full = (kept_reg == swerm_pkg::CNT_W'(swerm_pkg::DEPTH));
    assign rd_addr   = cmd.drop_rd ? oldest_reg : ring_pos(oldest_reg, scan_idx_reg);
    assign wr_addr   = kept_full ? oldest_reg : ring_pos(oldest_reg, kept_reg);
    assign r3_sum    = r3_reg + swerm_pkg::REM_W'(2);
    assign r5_sum    = r5_reg + swerm_pkg::REM_W'(2);

    assign status.kept_zero = (kept_reg == '0);
    assign status.drop_ok   = !early_keep_reg && (rd_data_reg <= limit_reg);
    assign status.scan_more = (scan_idx_reg != kept_reg);
    assign status.pipe_busy = rd_vld_reg || hit_vld_reg;

    assign rate_one_minute    = sat_rate(q1_reg);
    assign rate_three_minutes = sat_rate(q3_reg);
    assign rate_five_minutes  = sat_rate(q5_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.write_stamp)
        begin
            stamp_mem[wr_addr] <= now_reg;
        end
        if (cmd.drop_rd || cmd.scan_rd)
        begin
            rd_data_reg <= stamp_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg        <= now_us;
            limit_reg      <= now_us - swerm_pkg::KEEP_US;
            early_keep_reg <= now_us < swerm_pkg::KEEP_US;
            thr1_reg       <= now_us - swerm_pkg::MINUTE_US;
            thr3_reg       <= now_us - swerm_pkg::THREE_MIN_US;
            thr5_reg       <= now_us - swerm_pkg::KEEP_US;
            early1_reg     <= now_us < swerm_pkg::MINUTE_US;
            early3_reg     <= now_us < swerm_pkg::THREE_MIN_US;
            early5_reg     <= now_us < swerm_pkg::KEEP_US;
        end
        if (rd_vld_reg)
        begin
            hit1_reg <= early1_reg || (rd_data_reg >= thr1_reg);
            hit3_reg <= early3_reg || (rd_data_reg >= thr3_reg);
            hit5_reg <= early5_reg || (rd_data_reg >= thr5_reg);
        end
        if (cmd.start_scan)
        begin
            q1_reg <= '0;
            q3_reg <= '0;
            q5_reg <= '0;
            r3_reg <= swerm_pkg::REM_W'(3);
            r5_reg <= swerm_pkg::REM_W'(5);
        end
        else if (hit_vld_reg)
        begin
            if (hit1_reg)
            begin
                q1_reg <= q1_reg + swerm_pkg::CNT_W'(1);
            end
            if (hit3_reg)
            begin
                if (r3_sum >= swerm_pkg::REM_W'(6))
                begin
                    r3_reg <= r3_sum - swerm_pkg::REM_W'(6);
                    q3_reg <= q3_reg + swerm_pkg::CNT_W'(1);
                end
                else
                begin
                    r3_reg <= r3_sum;
                end
            end
            if (hit5_reg)
            begin
                if (r5_sum >= swerm_pkg::REM_W'(10))
                begin
                    r5_reg <= r5_sum - swerm_pkg::REM_W'(10);
                    q5_reg <= q5_reg + swerm_pkg::CNT_W'(1);
                end
                else
                begin
                    r5_reg <= r5_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg   <= '0;
            kept_reg     <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            hit_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= cmd.scan_rd;
            hit_vld_reg <= rd_vld_reg;
            if (cmd.start_scan)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= scan_idx_reg + swerm_pkg::CNT_W'(1);
            end
            if (cmd.drop_adv)
            begin
                oldest_reg <= ring_pos(oldest_reg, swerm_pkg::CNT_W'(1));
                kept_reg   <= kept_reg - swerm_pkg::CNT_W'(1);
            end
            else if (cmd.write_stamp)
            begin
                if (kept_full)
                begin
                    oldest_reg <= ring_pos(oldest_reg, swerm_pkg::CNT_W'(1));
                end
                else
                begin
                    kept_reg <= kept_reg + swerm_pkg::CNT_W'(1);
                end
            end
        end
    end

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= swerm_pkg::CNT_W'(swerm_pkg::DEPTH))
        else $error("kept count beyond depth");

    a_adv_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_adv |-> kept_reg != '0)
        else $error("drop from empty ring");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> scan_idx_reg < kept_reg)
        else $error("scan read past kept stamps");

    a_hit_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        hit_vld_reg |-> $past(rd_vld_reg))
        else $error("hit stage without read");

endmodule

// File: rtl/swerm_ctrl.sv
module swerm_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     opcode,
    input  swerm_pkg::swerm_status_t status,
    output swerm_pkg::swerm_cmd_t    cmd,
    output logic                     busy,
    output logic                     done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP_RD,
        ST_DROP_CHK,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (opcode == swerm_pkg::OP_QUERY)
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DROP_RD;
                    end
                end
            end
            ST_DROP_RD:
            begin
                if (status.kept_zero)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    cmd.drop_rd = 1'b1;
                    state_next  = ST_DROP_CHK;
                end
            end
            ST_DROP_CHK:
            begin
                if (status.drop_ok)
                begin
                    cmd.drop_adv = 1'b1;
                    state_next   = ST_DROP_RD;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_stamp = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (status.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE)
        else $error("result strobe while busy");

    a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == swerm_pkg::OP_QUERY) |=> state_reg == ST_SCAN)
        else $error("query did not start a scan");

    a_record_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> !done_reg)
        else $error("record produced a result");

endmodule

// File: rtl/sliding_window_event_rate_meter_top.sv
// channel   dir  handshake           fields
// command   in   start && !busy      opcode, now_us
// result    out  done (one cycle)    rate_one_minute, rate_three_minutes, rate_five_minutes
//
// Query: one stamp memory read per kept entry (up to 1024), then the read pipeline drains.
// Record: one memory read per dropped stamp plus one for the oldest stamp that stays.
// Reset clears the ring pointers, scan index and valid flags; the memory needs no clearing.
// busy stays high until the item completes; the result strobe cannot be stalled.
module sliding_window_event_rate_meter_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [swerm_pkg::STAMP_W-1:0] now_us,
    output logic                          done,
    output logic [swerm_pkg::RATE_W-1:0]  rate_one_minute,
    output logic [swerm_pkg::RATE_W-1:0]  rate_three_minutes,
    output logic [swerm_pkg::RATE_W-1:0]  rate_five_minutes
);

    swerm_pkg::swerm_cmd_t    cmd;
    swerm_pkg::swerm_status_t status;

    swerm_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    swerm_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .now_us             (now_us),
        .status             (status),
        .rate_one_minute    (rate_one_minute),
        .rate_three_minutes (rate_three_minutes),
        .rate_five_minutes  (rate_five_minutes)
    );

endmodule
